/* rtl/dvm_pkg.sv */
// ----------------------------------------------------------------------------
// dvm_pkg : shared types and constants of the depth valid-mean downsampler
// Frame geometry, field widths, payload structs and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dvm_pkg;

  // Output frame geometry; the raw frame is twice as wide and twice as tall in 2x mode.
  localparam int OUT_WIDTH  = 640;
  localparam int OUT_HEIGHT = 480;

  localparam int COL_W  = $clog2(2 * OUT_WIDTH + 1);
  localparam int ROW_W  = $clog2(2 * OUT_HEIGHT + 1);
  localparam int ADDR_W = $clog2(OUT_WIDTH);

  localparam logic [COL_W-1:0] RAW_W_PASS = COL_W'(OUT_WIDTH);
  localparam logic [COL_W-1:0] RAW_W_2X   = COL_W'(2 * OUT_WIDTH);
  localparam logic [ROW_W-1:0] RAW_H_PASS = ROW_W'(OUT_HEIGHT);
  localparam logic [ROW_W-1:0] RAW_H_2X   = ROW_W'(2 * OUT_HEIGHT);

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 17;              // sum of one sample pair
  localparam int CNT_W    = 2;               // valid count of one pair
  localparam int ENTRY_W  = SUM_W + CNT_W;   // line store word
  localparam int TSUM_W   = SUM_W + 1;       // sum of a 2x2 block
  localparam int TCNT_W   = CNT_W + 1;       // valid count of a 2x2 block
  localparam int DIVD_W   = TSUM_W;          // divider dividend width
  localparam int DIVS_W   = 8;               // divider divisor width

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWNSAMPLE_2X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_DIVISOR = 1'b1;
  localparam int CFG_DATA_W = 8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_depth;
    logic                frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] depth_high;
    logic [7:0] depth_low;
    logic       last_of_frame;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic take;          // input transaction completes this cycle
    logic start_pass;    // divide the incoming sample by the divisor
    logic start_mean;    // divide the block sum by its valid count
    logic start_scale;   // divide the block mean by the divisor
    logic load_out;      // move the quotient into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_pass;       // incoming sample yields a pass-through result
    logic is_bottom;     // incoming sample closes a 2x2 block
    logic div_done;      // divider quotient is ready
    logic out_free;      // output register can take a new result
  } ctrl_sts_t;

endpackage

/* rtl/dvm_ram.sv */
// ----------------------------------------------------------------------------
// dvm_ram : generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/dvm_div.sv */
// ----------------------------------------------------------------------------
// dvm_div : iterative restoring divider
// One quotient bit per cycle; done stays high until the next start.
// ----------------------------------------------------------------------------
module dvm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dvm_pkg::DIVD_W-1:0] dividend,
  input  logic [dvm_pkg::DIVS_W-1:0] divisor,
  output logic                      done,
  output logic [dvm_pkg::DIVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(dvm_pkg::DIVD_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(dvm_pkg::DIVD_W - 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [dvm_pkg::DIVS_W-1:0] d_r, d_nxt;
  logic [dvm_pkg::DIVS_W-1:0] rem_r, rem_nxt;
  logic [dvm_pkg::DIVD_W-1:0] q_r, q_nxt;
  logic [dvm_pkg::DIVS_W:0]   rem_sh;
  logic [dvm_pkg::DIVS_W:0]   rem_sub;
  logic                       fits;

  always_comb begin
    rem_sh  = {rem_r, q_r[dvm_pkg::DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, d_r};
    fits    = rem_sh >= {1'b0, d_r};

    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = '0;
      d_nxt    = divisor;
      rem_nxt  = '0;
      q_nxt    = dividend;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      rem_nxt = fits ? rem_sub[dvm_pkg::DIVS_W-1:0] : rem_sh[dvm_pkg::DIVS_W-1:0];
      q_nxt   = {q_r[dvm_pkg::DIVD_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* rtl/dvm_ctrl.sv */
// ----------------------------------------------------------------------------
// dvm_ctrl : sequencing state machine
// Accepts one transaction at a time and steps the datapath through the
// line store read and mean division (2x mode), the scale division and the output load.
// ----------------------------------------------------------------------------
module dvm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dvm_pkg::ctrl_sts_t sts,
  output dvm_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_READ      = 3'd1;
  localparam logic [2:0] S_DIV_MEAN  = 3'd2;
  localparam logic [2:0] S_DIV_SCALE = 3'd3;
  localparam logic [2:0] S_RESULT    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign take     = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd.take        = take;
    cmd.start_pass  = take && sts.is_pass;
    cmd.start_mean  = (state_r == S_READ);
    cmd.start_scale = (state_r == S_DIV_MEAN) && sts.div_done;
    cmd.load_out    = (state_r == S_RESULT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take && sts.is_pass) begin
          state_nxt = S_DIV_SCALE;
        end else if (take && sts.is_bottom) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_DIV_MEAN;
      end
      S_DIV_MEAN: begin
        if (sts.div_done) begin
          state_nxt = S_DIV_SCALE;
        end
      end
      S_DIV_SCALE: begin
        if (sts.div_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/dvm_dp.sv */
// ----------------------------------------------------------------------------
// dvm_dp : datapath
// Position counters, configuration registers, pair accumulation, line store,
// shared divider and output register.
// ----------------------------------------------------------------------------
module dvm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dvm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dvm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  dvm_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dvm_pkg::out_item_t               out_data,
  input  dvm_pkg::ctrl_cmd_t               cmd,
  output dvm_pkg::ctrl_sts_t               sts
);

  // Configuration
  logic                       mode_2x_r;
  logic [dvm_pkg::DIVS_W-1:0] divisor_r;
  logic [dvm_pkg::DIVS_W-1:0] eff_divisor;

  // Position and pair state
  logic [dvm_pkg::COL_W-1:0]    col_r, col_nxt, col_eff, col_inc, raw_w;
  logic [dvm_pkg::ROW_W-1:0]    row_r, row_nxt, row_eff, row_inc, raw_h;
  logic [dvm_pkg::SAMPLE_W-1:0] held_r;
  logic                         in_rng, is_last;
  logic                         is_left, is_top;

  // Pair and block sums
  logic [dvm_pkg::SUM_W-1:0]  pair_sum;
  logic [dvm_pkg::CNT_W-1:0]  pair_cnt;
  logic [dvm_pkg::SUM_W-1:0]  psum_r;
  logic [dvm_pkg::CNT_W-1:0]  pcnt_r;
  logic                       last_r;
  logic [dvm_pkg::ENTRY_W-1:0] rd_entry;
  logic [dvm_pkg::TSUM_W-1:0] tot_sum;
  logic [dvm_pkg::TCNT_W-1:0] tot_cnt;
  logic [dvm_pkg::ADDR_W-1:0] pair_idx;

  // Divider
  logic                       div_start;
  logic [dvm_pkg::DIVD_W-1:0] div_dividend;
  logic [dvm_pkg::DIVS_W-1:0] div_divisor;
  logic                       div_done;
  logic [dvm_pkg::DIVD_W-1:0] div_quot;

  // Output register
  logic               out_valid_r;
  dvm_pkg::out_item_t out_data_r;

  // -- configuration ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_2x_r <= 1'b0;
      divisor_r <= dvm_pkg::DIVS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        dvm_pkg::CFG_DOWNSAMPLE_2X: mode_2x_r <= cfg_wdata[0];
        dvm_pkg::CFG_DEPTH_DIVISOR: divisor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a zero divisor acts as one
  assign eff_divisor = (divisor_r == '0) ? dvm_pkg::DIVS_W'(1) : divisor_r;

  // -- position classification of the incoming sample ------------------------
  always_comb begin
    col_eff = in_data.frame_start ? '0 : col_r;
    row_eff = in_data.frame_start ? '0 : row_r;
    raw_w   = mode_2x_r ? dvm_pkg::RAW_W_2X : dvm_pkg::RAW_W_PASS;
    raw_h   = mode_2x_r ? dvm_pkg::RAW_H_2X : dvm_pkg::RAW_H_PASS;
    in_rng  = (col_eff < raw_w) && (row_eff < raw_h);
    is_last = (col_eff == raw_w - 1'b1) && (row_eff == raw_h - 1'b1);

    sts.is_pass   = in_rng && !mode_2x_r;
    is_left       = in_rng && mode_2x_r && !col_eff[0];
    is_top        = in_rng && mode_2x_r && col_eff[0] && !row_eff[0];
    sts.is_bottom = in_rng && mode_2x_r && col_eff[0] && row_eff[0];

    // divider and output register status
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || !out_stall;

    pair_idx = col_eff[dvm_pkg::ADDR_W:1];
    pair_sum = {1'b0, held_r} + {1'b0, in_data.raw_depth};
    pair_cnt = {1'b0, (held_r != '0)} + {1'b0, (in_data.raw_depth != '0)};

    // advance the raster position, wrap at the frame edge of this mode
    col_inc = col_eff + 1'b1;
    row_inc = row_eff + 1'b1;
    col_nxt = col_inc;
    row_nxt = row_eff;
    if (col_inc >= raw_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= raw_h) ? '0 : row_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else if (cmd.take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (is_left) begin
        held_r <= in_data.raw_depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      last_r <= is_last;
      psum_r <= pair_sum;
      pcnt_r <= pair_cnt;
    end
  end

  // -- line store: top-row pair sum and count per output column --------------
  dvm_ram #(
    .WIDTH (dvm_pkg::ENTRY_W),
    .DEPTH (dvm_pkg::OUT_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (cmd.take && is_top),
    .waddr (pair_idx),
    .wdata ({pair_cnt, pair_sum}),
    .re    (cmd.take && sts.is_bottom),
    .raddr (pair_idx),
    .rdata (rd_entry)
  );

  assign tot_sum = {1'b0, psum_r} + {1'b0, rd_entry[dvm_pkg::SUM_W-1:0]};
  assign tot_cnt = {1'b0, pcnt_r} + {1'b0, rd_entry[dvm_pkg::ENTRY_W-1:dvm_pkg::SUM_W]};

  // -- shared divider --------------------------------------------------------
  always_comb begin
    div_start    = cmd.start_pass || cmd.start_mean || cmd.start_scale;
    div_dividend = {2'b00, in_data.raw_depth};
    div_divisor  = eff_divisor;
    if (cmd.start_mean) begin
      div_dividend = tot_sum;
      div_divisor  = (tot_cnt == '0) ? dvm_pkg::DIVS_W'(1) : dvm_pkg::DIVS_W'(tot_cnt);
    end else if (cmd.start_scale) begin
      div_dividend = {2'b00, div_quot[dvm_pkg::SAMPLE_W-1:0]};
    end
  end

  dvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // -- output register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.depth_high    <= div_quot[15:8];
      out_data_r.depth_low     <= div_quot[7:0];
      out_data_r.last_of_frame <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/depth_valid_mean_downsampler.sv */
// ----------------------------------------------------------------------------
// depth_valid_mean_downsampler : depth image valid-pixel mean downsampler
// Scales raw 16-bit depth samples by a configured divisor, optionally after
// averaging the nonzero samples of each 2x2 raw block.
// ----------------------------------------------------------------------------
// Raw depth samples enter in raster order, one per input transaction, and a
// zero sample means no measurement. With downsample_2x clear the raw frame is
// OUT_WIDTH x OUT_HEIGHT and every sample gives one output transaction; with
// it set the raw frame is twice as wide and twice as tall and the bottom-right
// sample of each 2x2 block gives one output carrying the truncated mean of the
// block's nonzero samples (0 when all are zero). Every output depth is divided
// by depth_divisor (0 acts as 1) and sent as a high and a low byte;
// last_of_frame marks the final output of a frame. frame_start restarts the
// position counters; without it the counters wrap at the frame end. The block
// works on one transaction at a time. A sample that only updates state (left
// sample, top-row pair) is taken without a division; a pass-through sample
// runs the shared restoring divider once and a block-closing sample runs it
// twice (mean, then scale). The divider produces one quotient bit per cycle
// over 18 steps, and the input stalls while it works. A finished result waits
// in the output register while the next transaction is taken. The line store
// is a RAM with registered read and needs no clearing after reset. The user
// must write configuration only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module depth_valid_mean_downsampler (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [dvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dvm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // raw sample channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dvm_pkg::in_item_t              in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output dvm_pkg::out_item_t             out_data
);

  dvm_pkg::ctrl_cmd_t cmd;
  dvm_pkg::ctrl_sts_t sts;

  // Sequence each transaction: accept and, for a sample that gives a result, the
  // optional line store read, divisions and hand-off to the output register.
  dvm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold counters, configuration, line store, divider and output register.
  dvm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/dvm_checker.sv */
// ----------------------------------------------------------------------------
// dvm_checker : port-level checks of the downsampler
// Watches the channel handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
module dvm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dvm_pkg::out_item_t out_data
);

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // reset empties the output register
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input stall starts only right after a transaction was taken
  a_stall_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stalled without a preceding transaction");

  // a new result appears only at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the input side was idle");

endmodule

bind depth_valid_mean_downsampler dvm_checker u_dvm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
